/* sv/hsvc_pkg.sv */
`timescale 1ns / 1ps

package hsvc_pkg;

  localparam int HueW   = 16;
  localparam int LevelW = 8;
  localparam int ChanW  = 8;
  localparam int PackW  = 9;
  localparam int SectW  = 3;
  localparam int FracW  = 16;
  localparam int ScaleW = HueW + SectW;      // hue * 6
  localparam int TermW  = 24;                // 255 * 65536 fits
  localparam int NumW   = TermW + LevelW;    // level * term
  localparam int HiW    = NumW - FracW;      // numerator over 65536

  localparam logic [LevelW-1:0] LevelMax  = LevelW'(255);
  localparam logic [TermW-1:0]  FullScale = TermW'(255 * 65536);

  typedef enum logic [SectW-1:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYAN = 3'd2,
    SECT_CYAN_BLU = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5
  } sect_t;

  // floor(x / 255), exact for x <= 255 * 255
  function automatic logic [ChanW-1:0] div255(input logic [HiW-1:0] x);
    logic [HiW-1:0] sum;
    sum = x + HiW'(x[HiW-1:ChanW]) + HiW'(1);
    return sum[HiW-1:ChanW];
  endfunction

endpackage

/* sv/hsvc_if.sv */
`timescale 1ns / 1ps

interface hsvc_in_if import hsvc_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [HueW-1:0]   hue_fraction;
  logic [LevelW-1:0] saturation_level;
  logic [LevelW-1:0] value_level;

  modport source (output valid, hue_fraction, saturation_level, value_level, input ready);
  modport sink   (input valid, hue_fraction, saturation_level, value_level, output ready);
endinterface

interface hsvc_out_if import hsvc_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_byte;
  logic [ChanW-1:0] green_byte;
  logic [ChanW-1:0] blue_byte;
  logic [PackW-1:0] packed_rgb333;

  modport source (output valid, red_byte, green_byte, blue_byte, packed_rgb333, input ready);
  modport sink   (input valid, red_byte, green_byte, blue_byte, packed_rgb333, output ready);
endinterface

/* sv/hsvc_term_pipe.sv */
`timescale 1ns / 1ps

// Three register stages forming v, p, q, t; q and t divide after stage 3.
module hsvc_term_pipe import hsvc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [HueW-1:0]   hue,
  input  logic [LevelW-1:0] sat,
  input  logic [LevelW-1:0] val,
  output sect_t             sect,
  output logic [ChanW-1:0]  v_byte,
  output logic [ChanW-1:0]  p_byte,
  output logic [ChanW-1:0]  q_byte,
  output logic [ChanW-1:0]  t_byte
);

  logic [ScaleW-1:0] scaled;

  // stage 1
  logic [SectW-1:0]  sect1_r;
  logic [FracW-1:0]  frac1_r;
  logic [LevelW-1:0] sat1_r, val1_r;
  logic [HiW-1:0]    pnum1_r;
  // stage 2
  logic [SectW-1:0]  sect2_r;
  logic [LevelW-1:0] val2_r;
  logic [HiW-1:0]    pnum2_r;
  logic [TermW-1:0]  aq2_r, at2_r;
  logic [TermW-1:0]  fs;
  // stage 3
  logic [SectW-1:0]  sect3_r;
  logic [LevelW-1:0] val3_r;
  logic [ChanW-1:0]  p3_r;
  logic [HiW-1:0]    qhi3_r, thi3_r;
  logic [NumW-1:0]   qnum, tnum;

  // hue * 6 as two shifted adds
  assign scaled = ScaleW'({hue, 2'b00}) + ScaleW'({hue, 1'b0});
  assign fs     = TermW'(frac1_r) * TermW'(sat1_r);
  assign qnum   = NumW'(val2_r) * NumW'(aq2_r);
  assign tnum   = NumW'(val2_r) * NumW'(at2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sect1_r <= scaled[ScaleW-1:FracW];
      frac1_r <= scaled[FracW-1:0];
      sat1_r  <= sat;
      val1_r  <= val;
      pnum1_r <= HiW'(val) * HiW'(LevelMax - sat);

      sect2_r <= sect1_r;
      val2_r  <= val1_r;
      pnum2_r <= pnum1_r;
      aq2_r   <= FullScale - fs;
      at2_r   <= (FullScale - TermW'({sat1_r, 16'h0000})) + fs;

      sect3_r <= sect2_r;
      val3_r  <= val2_r;
      p3_r    <= div255(pnum2_r);
      qhi3_r  <= qnum[NumW-1:FracW];
      thi3_r  <= tnum[NumW-1:FracW];
    end
  end

  assign sect   = sect_t'(sect3_r);
  assign v_byte = val3_r;
  assign p_byte = p3_r;
  assign q_byte = div255(qhi3_r);
  assign t_byte = div255(thi3_r);

endmodule

/* sv/hsv_to_rgb333_pixel_convert_top.sv */
`timescale 1ns / 1ps

// HSV to RGB pixel converter with RGB333 packing.
//
// in_pix  : one beat per pixel - hue (16-bit fraction of a turn), saturation
//           and value bytes (255 = full scale).
// out_pix : one beat per pixel - red, green, blue bytes and the packed
//           9-bit word {blue[7:5], green[7:5], red[7:5]}.
//
// Four register stages: hue*6 and v*(255-s); f*s into the q/t terms;
// v*term products; divide-by-255, sector select and output register.
// One pixel per clock is sustained while out_pix.ready stays high; the
// v*term multiplies in stage 3 set the depth.
//
// The whole pipe advances together whenever the output register is empty
// or being taken, so in_pix.ready follows out_pix.ready while a result is
// waiting. A stall freezes every stage; nothing is dropped or repeated.
// Reset clears the valid bits only; the data registers are not reset.
module hsv_to_rgb333_pixel_convert_top import hsvc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  hsvc_in_if.sink           in_pix,
  hsvc_out_if.source        out_pix
);

  logic             en;
  logic             v1_r, v2_r, v3_r, out_valid_r;
  sect_t            sect;
  logic [ChanW-1:0] v_byte, p_byte, q_byte, t_byte;
  logic [ChanW-1:0] red_nxt, green_nxt, blue_nxt;
  logic [ChanW-1:0] red_r, green_r, blue_r;

  // advance when the output slot is free or being drained
  assign en           = !out_valid_r || out_pix.ready;
  assign in_pix.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_pix.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  hsvc_term_pipe u_terms (
    .clk    (clk),
    .en     (en),
    .hue    (in_pix.hue_fraction),
    .sat    (in_pix.saturation_level),
    .val    (in_pix.value_level),
    .sect   (sect),
    .v_byte (v_byte),
    .p_byte (p_byte),
    .q_byte (q_byte),
    .t_byte (t_byte)
  );

  // sector routing of v, p, q, t onto the three channels
  always_comb begin
    case (sect)
      SECT_RED_YEL: begin
        red_nxt = v_byte; green_nxt = t_byte; blue_nxt = p_byte;
      end
      SECT_YEL_GRN: begin
        red_nxt = q_byte; green_nxt = v_byte; blue_nxt = p_byte;
      end
      SECT_GRN_CYAN: begin
        red_nxt = p_byte; green_nxt = v_byte; blue_nxt = t_byte;
      end
      SECT_CYAN_BLU: begin
        red_nxt = p_byte; green_nxt = q_byte; blue_nxt = v_byte;
      end
      SECT_BLU_MAG: begin
        red_nxt = t_byte; green_nxt = p_byte; blue_nxt = v_byte;
      end
      default: begin
        red_nxt = v_byte; green_nxt = p_byte; blue_nxt = q_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_pix.valid         = out_valid_r;
  assign out_pix.red_byte      = red_r;
  assign out_pix.green_byte    = green_r;
  assign out_pix.blue_byte     = blue_r;
  assign out_pix.packed_rgb333 = {blue_r[7:5], green_r[7:5], red_r[7:5]};

endmodule

/* sv/hsvc_checker.sv */
`timescale 1ns / 1ps

module hsvc_checker import hsvc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ChanW-1:0] red,
  input logic [ChanW-1:0] green,
  input logic [ChanW-1:0] blue,
  input logic [PackW-1:0] packed_word
);

  // output beat held while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(packed_word))
    else $error("output beat changed during stall");

  // a stalled result blocks new input
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // an empty output slot never refuses input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty pipe");

  // packed word carries top three bits of each channel
  a_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> packed_word == {blue[7:5], green[7:5], red[7:5]})
    else $error("packed word mismatch");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind hsv_to_rgb333_pixel_convert_top hsvc_checker u_hsvc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_pix.ready),
  .out_valid   (out_pix.valid),
  .out_ready   (out_pix.ready),
  .red         (out_pix.red_byte),
  .green       (out_pix.green_byte),
  .blue        (out_pix.blue_byte),
  .packed_word (out_pix.packed_rgb333)
);
